>>> hw/rtl/pidl_pkg.sv
// Shared types and constants of the positional insert and delete list.
package pidl_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned POS_W         = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_DELETE,
    S_READ,
    S_RESP
  } state_e;

endpackage

>>> hw/rtl/pidl_ram.sv
// Generic single-write, single-read memory with a registered read port.
module pidl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/positional_insert_delete_list.sv
// Top level of the positional insert and delete list over one word memory.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | cmd_i, position_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, count_o, read_value_o
//
// A command passes through its transfer, then its memory work, then the load
// of the result register. An insert shifts the entries from its position up,
// a delete shifts the entries above its position down, a read fetches one
// entry, and a failed command does no memory work. The single memory write
// port moves one entry per cycle while the read of the next entry overlaps
// it. Reset clears the count and the control state; the memory is not
// cleared, since only positions below the count are ever read. A stalled
// result stays in the output register while the next command is taken and
// worked on.
module positional_insert_delete_list #(
  parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pidl_pkg::CMD_W-1:0]          cmd_i,
  input  logic [pidl_pkg::POS_W-1:0]          position_i,
  input  logic signed [pidl_pkg::WORD_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pidl_pkg::STATUS_W-1:0]       status_o,
  output logic [pidl_pkg::COUNT_W-1:0]        count_o,
  output logic signed [pidl_pkg::WORD_W-1:0]  read_value_o
);

  // Address width, count width, and a working width that holds the count,
  // the position and the four-bit count field alike.
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MW0  = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;
  localparam int unsigned MW   = (MW0 > pidl_pkg::COUNT_W) ? MW0 : pidl_pkg::COUNT_W;

  pidl_pkg::state_e  state_q, state_d;
  pidl_pkg::cmd_e    cmd_q, cmd_d;
  pidl_pkg::status_e st_q, st_d;

  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [MW-1:0]                     pos_q, pos_d;
  logic [pidl_pkg::WORD_W-1:0]       val_q, val_d;
  logic [MW-1:0]                     src_q, src_d;
  logic [MW-1:0]                     wr_q, wr_d;
  logic                              more_q, more_d;
  logic                              pend_q, pend_d;
  logic [pidl_pkg::WORD_W-1:0]       rd_q, rd_d;

  logic                              out_valid_q, out_valid_d;
  pidl_pkg::status_e                 out_st_q, out_st_d;
  logic [pidl_pkg::COUNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic [pidl_pkg::WORD_W-1:0]       out_rd_q, out_rd_d;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [pidl_pkg::WORD_W-1:0]       mem_wdata;
  logic [AW-1:0]                     mem_raddr;
  logic [pidl_pkg::WORD_W-1:0]       mem_rdata;

  logic [MW-1:0]                     pos_in;
  logic [MW-1:0]                     cnt_ext;
  logic [MW-1:0]                     cnt_new;
  logic                              accept;

  pidl_ram #(
    .WIDTH (pidl_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pos_in     = MW'(position_i);
  assign cnt_ext    = MW'(cnt_q);
  assign in_stall_o = (state_q != pidl_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    st_d        = st_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    src_d       = src_q;
    wr_d        = wr_q;
    more_d      = more_q;
    pend_d      = pend_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    out_rd_d    = out_rd_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = src_q[AW-1:0];
    cnt_new     = cnt_ext;

    case (state_q)
      pidl_pkg::S_IDLE: begin
        // The read of the addressed entry is issued on the transfer cycle.
        mem_raddr = pos_in[AW-1:0];
        if (accept) begin
          cmd_d  = pidl_pkg::cmd_e'(cmd_i);
          pos_d  = pos_in;
          val_d  = value_i;
          rd_d   = '0;
          pend_d = 1'b0;
          st_d   = pidl_pkg::ST_RANGE;
          state_d = pidl_pkg::S_RESP;
          case (pidl_pkg::cmd_e'(cmd_i))
            pidl_pkg::CMD_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                st_d = pidl_pkg::ST_FULL;
              end else if (pos_in <= cnt_ext) begin
                st_d    = pidl_pkg::ST_OK;
                state_d = pidl_pkg::S_INSERT;
                src_d   = cnt_ext - MW'(1);
                more_d  = (cnt_ext != pos_in);
              end
            end
            pidl_pkg::CMD_DELETE: begin
              if (cnt_q == '0) begin
                st_d = pidl_pkg::ST_EMPTY;
              end else if (pos_in < cnt_ext) begin
                st_d    = pidl_pkg::ST_OK;
                state_d = pidl_pkg::S_DELETE;
                src_d   = pos_in + MW'(1);
                more_d  = ((pos_in + MW'(1)) < cnt_ext);
              end
            end
            pidl_pkg::CMD_READ: begin
              if (cnt_q == '0) begin
                st_d = pidl_pkg::ST_EMPTY;
              end else if (pos_in < cnt_ext) begin
                st_d    = pidl_pkg::ST_OK;
                state_d = pidl_pkg::S_READ;
              end
            end
            default: begin
              st_d = pidl_pkg::ST_RANGE;
            end
          endcase
        end
      end

      pidl_pkg::S_INSERT: begin
        // Entries move up from the top: write the entry read last cycle one
        // place higher while the next lower one is read.
        mem_we = pend_q;
        if (more_q) begin
          pend_d = 1'b1;
          wr_d   = src_q + MW'(1);
          src_d  = src_q - MW'(1);
          more_d = (src_q != pos_q);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q[AW-1:0];
            mem_wdata = val_q;
            state_d   = pidl_pkg::S_RESP;
          end
        end
      end

      pidl_pkg::S_DELETE: begin
        // Entries move down from just above the removed one.
        mem_we = pend_q;
        if (more_q) begin
          pend_d = 1'b1;
          wr_d   = src_q - MW'(1);
          src_d  = src_q + MW'(1);
          more_d = ((src_q + MW'(1)) < cnt_ext);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = pidl_pkg::S_RESP;
          end
        end
      end

      pidl_pkg::S_READ: begin
        rd_d    = mem_rdata;
        state_d = pidl_pkg::S_RESP;
      end

      pidl_pkg::S_RESP: begin
        if (st_q == pidl_pkg::ST_OK && cmd_q == pidl_pkg::CMD_INSERT) begin
          cnt_new = cnt_ext + MW'(1);
        end else if (st_q == pidl_pkg::ST_OK && cmd_q == pidl_pkg::CMD_DELETE) begin
          cnt_new = cnt_ext - MW'(1);
        end
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_cnt_d   = cnt_new[pidl_pkg::COUNT_W-1:0];
          out_rd_d    = rd_q;
          cnt_d       = cnt_new[CW-1:0];
          state_d     = pidl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pidl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidl_pkg::S_IDLE;
      cnt_q       <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    st_q      <= st_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    src_q     <= src_d;
    wr_q      <= wr_d;
    rd_q      <= rd_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
    out_rd_q  <= out_rd_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign count_o      = out_cnt_q;
  assign read_value_o = out_rd_q;

endmodule

>>> hw/rtl/pidl_checker.sv
// Port-level checks of the positional insert and delete list, bound to its top level.
module pidl_checker #(
  parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [pidl_pkg::CMD_W-1:0]          cmd_i,
  input logic [pidl_pkg::POS_W-1:0]          position_i,
  input logic signed [pidl_pkg::WORD_W-1:0]  value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [pidl_pkg::STATUS_W-1:0]       status_o,
  input logic [pidl_pkg::COUNT_W-1:0]        count_o,
  input logic signed [pidl_pkg::WORD_W-1:0]  read_value_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(count_o) && $stable(read_value_o))
    else $error("stalled result changed");

  // A failed command carries a zero read word.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pidl_pkg::ST_OK |-> read_value_o == '0)
    else $error("failed command returned a word");

  // A full report means the list holds its capacity.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pidl_pkg::ST_FULL
      |-> count_o == pidl_pkg::COUNT_W'(DEPTH))
    else $error("full status with wrong count");

  // An empty report means no entries are held.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pidl_pkg::ST_EMPTY |-> count_o == '0)
    else $error("empty status with nonzero count");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (.*);

>>> test/positional_insert_delete_list_tb.sv
// Self-checking testbench for the positional insert and delete list.
module positional_insert_delete_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The list is built at its default capacity, so positions 0 to 7 cover it.
  localparam int unsigned LIST_DEPTH = pidl_pkg::DEPTH_DEFAULT;

  // Command code 3 is not an operation, but the block must still answer it.
  localparam logic [pidl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [pidl_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [pidl_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // The longest command shifts every entry, so a handful of cycles past that
  // is enough for a stray result to show up after the last expected one.
  localparam int unsigned DRAIN_CYCLES   = LIST_DEPTH + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 157;

  // One expected answer: status, count after the command, and read word.
  typedef struct packed {
    pidl_pkg::status_e                   status;
    logic [pidl_pkg::COUNT_W-1:0]        count;
    logic signed [pidl_pkg::WORD_W-1:0]  word;
  } list_reply_t;

  // Mirrors the list contents and holds the answers still owed by the block.
  class list_scoreboard;
    logic signed [pidl_pkg::WORD_W-1:0] slots [LIST_DEPTH];
    int unsigned              fill;
    list_reply_t              awaited [$];
    int unsigned              mismatches;
    int unsigned              op_tally [4];
    int unsigned              status_tally [4];
    int unsigned              peak_fill;

    function new();
      fill       = 0;
      mismatches = 0;
      peak_fill  = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // Applies one accepted command to the mirror and queues its answer.
    function void note_command(input logic [pidl_pkg::CMD_W-1:0] op,
                               input logic [pidl_pkg::POS_W-1:0] pos,
                               input logic signed [pidl_pkg::WORD_W-1:0] word);
      list_reply_t reply;
      int          i;
      reply.status = pidl_pkg::ST_RANGE;
      reply.word   = '0;
      case (op)
        pidl_pkg::CMD_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            reply.status = pidl_pkg::ST_FULL;
          end else if (pos > fill) begin
            reply.status = pidl_pkg::ST_RANGE;
          end else begin
            for (i = fill; i > int'(pos); i--) slots[i] = slots[i-1];
            slots[pos]   = word;
            fill++;
            reply.status = pidl_pkg::ST_OK;
          end
        end
        pidl_pkg::CMD_DELETE: begin
          if (fill == 0) begin
            reply.status = pidl_pkg::ST_EMPTY;
          end else if (pos >= fill) begin
            reply.status = pidl_pkg::ST_RANGE;
          end else begin
            for (i = pos; i + 1 < int'(fill); i++) slots[i] = slots[i+1];
            fill--;
            reply.status = pidl_pkg::ST_OK;
          end
        end
        pidl_pkg::CMD_READ: begin
          if (fill == 0) begin
            reply.status = pidl_pkg::ST_EMPTY;
          end else if (pos >= fill) begin
            reply.status = pidl_pkg::ST_RANGE;
          end else begin
            reply.word   = slots[pos];
            reply.status = pidl_pkg::ST_OK;
          end
        end
        default: begin
          reply.status = pidl_pkg::ST_RANGE;
        end
      endcase
      reply.count = pidl_pkg::COUNT_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      op_tally[op]++;
      status_tally[reply.status]++;
      awaited.push_back(reply);
    endfunction

    // Compares one accepted result with the oldest answer still owed.
    function void check_reply(input logic [pidl_pkg::STATUS_W-1:0] status,
                              input logic [pidl_pkg::COUNT_W-1:0] count,
                              input logic signed [pidl_pkg::WORD_W-1:0] word);
      list_reply_t want;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with nothing expected: status %0d count %0d read_value %0d",
                 $time, status, count, word);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
        $display("%0t ns: status mismatch: expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (count !== want.count) begin
        $display("%0t ns: count mismatch: expected %0d actual %0d", $time, want.count, count);
        mismatches++;
      end
      if (word !== want.word) begin
        $display("%0t ns: read_value mismatch: expected %0d actual %0d", $time, want.word, word);
        mismatches++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value; reset is held low.
  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_stall_o;
  logic [pidl_pkg::CMD_W-1:0]           cmd_i        = '0;
  logic [pidl_pkg::POS_W-1:0]           position_i   = '0;
  logic signed [pidl_pkg::WORD_W-1:0]   value_i      = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i  = 1'b0;
  logic [pidl_pkg::STATUS_W-1:0]        status_o;
  logic [pidl_pkg::COUNT_W-1:0]         count_o;
  logic signed [pidl_pkg::WORD_W-1:0]   read_value_o;

  // Percentages of cycles in which the command side holds back and the
  // result side stalls; the main sequence changes them between phases.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  list_scoreboard scoreboard = new();

  positional_insert_delete_list #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .read_value_o(read_value_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Offers one command and holds it steady until the block takes it. A gap,
  // when one is drawn, drops valid first; otherwise valid stays high and only
  // the payload moves on, so valid gets a single assignment per time step.
  task automatic send_cmd(input logic [pidl_pkg::CMD_W-1:0] op,
                          input logic [pidl_pkg::POS_W-1:0] pos,
                          input logic signed [pidl_pkg::WORD_W-1:0] word);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    position_i <= pos;
    value_i    <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The transfer happened at this edge, so the mirror moves on now.
    scoreboard.note_command(op, pos, word);
  endtask

  // Draws one command that keeps the list moving. Most positions are legal
  // for the current fill, so the list really grows, shifts and shrinks; the
  // rest land anywhere and exercise the range checks. The fill_up flag tilts
  // the mix toward inserts or deletes so both full and empty are reached.
  task automatic send_random(input bit fill_up);
    int unsigned                        roll;
    int unsigned                        held;
    logic [pidl_pkg::CMD_W-1:0]         op;
    logic [pidl_pkg::POS_W-1:0]         pos;
    logic signed [pidl_pkg::WORD_W-1:0] word;
    held = scoreboard.fill;
    roll = $urandom_range(99);
    if (roll < 4) begin
      op = CMD_UNUSED;
    end else if (roll < (fill_up ? 60 : 30)) begin
      op = pidl_pkg::CMD_INSERT;
    end else if (roll < (fill_up ? 78 : 70)) begin
      op = pidl_pkg::CMD_DELETE;
    end else begin
      op = pidl_pkg::CMD_READ;
    end
    if ($urandom_range(99) < 15) begin
      pos = pidl_pkg::POS_W'($urandom_range(LIST_DEPTH - 1));
    end else if (op == pidl_pkg::CMD_INSERT) begin
      pos = (held >= LIST_DEPTH) ? pidl_pkg::POS_W'($urandom_range(LIST_DEPTH - 1))
                                 : pidl_pkg::POS_W'($urandom_range(held));
    end else begin
      pos = (held == 0) ? '0 : pidl_pkg::POS_W'($urandom_range(held - 1));
    end
    // Now and then the word is an extreme, so sign and carry edges show up.
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0:       word = WORD_MIN;
        1:       word = WORD_MAX;
        2:       word = '1;
        default: word = '0;
      endcase
    end else begin
      word = $urandom;
    end
    send_cmd(op, pos, word);
  endtask

  // Result side: checks each accepted result, draws the stall for the next
  // cycle, and watches for a block that has stopped taking or giving transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        scoreboard.check_reply(status_o, count_o, read_value_o);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results still owed",
                 $time, idle_cycles, scoreboard.awaited.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    bit fill_up;
    int phase;
    int k;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the empty list, every failure status, the unused code,
    // inserts at front, middle and end, the full list, and word extremes.
    send_cmd(pidl_pkg::CMD_READ,   3'd0, '0);           // read from the empty list
    send_cmd(pidl_pkg::CMD_DELETE, 3'd3, '0);           // delete from the empty list
    send_cmd(CMD_UNUSED,           3'd0, '0);           // unused code on the empty list
    send_cmd(pidl_pkg::CMD_INSERT, 3'd1, 32'sd5);       // insert beyond the count
    send_cmd(pidl_pkg::CMD_INSERT, 3'd0, WORD_MAX);
    send_cmd(pidl_pkg::CMD_INSERT, 3'd1, WORD_MIN);     // append at the end
    send_cmd(pidl_pkg::CMD_INSERT, 3'd0, '1);           // push in at the front
    send_cmd(pidl_pkg::CMD_INSERT, 3'd1, '0);           // drop into the middle
    send_cmd(pidl_pkg::CMD_READ,   3'd4, '0);           // read at the count
    send_cmd(pidl_pkg::CMD_READ,   3'd7, '0);           // read far beyond the count
    send_cmd(pidl_pkg::CMD_DELETE, 3'd4, '0);           // delete at the count
    send_cmd(pidl_pkg::CMD_INSERT, 3'd4, 32'sh5555_5555);
    send_cmd(pidl_pkg::CMD_INSERT, 3'd2, 32'shAAAA_AAAA);
    send_cmd(pidl_pkg::CMD_INSERT, 3'd6, $urandom);
    send_cmd(pidl_pkg::CMD_INSERT, 3'd7, $urandom);     // last free slot, list now full
    send_cmd(pidl_pkg::CMD_INSERT, 3'd0, 32'sd1);       // insert into the full list
    send_cmd(pidl_pkg::CMD_INSERT, 3'd7, 32'sd2);
    send_cmd(pidl_pkg::CMD_READ,   3'd0, '0);
    send_cmd(pidl_pkg::CMD_READ,   3'd7, '0);
    send_cmd(CMD_UNUSED,           3'd7, WORD_MAX);     // unused code on the full list
    send_cmd(pidl_pkg::CMD_DELETE, 3'd7, '0);           // remove the last entry
    send_cmd(pidl_pkg::CMD_DELETE, 3'd0, '0);           // remove the first entry
    send_cmd(pidl_pkg::CMD_DELETE, 3'd3, '0);           // remove from the middle
    send_cmd(pidl_pkg::CMD_INSERT, 3'd7, 32'sd3);       // insert beyond the count again

    // Random part in four flow-control phases: free running, a bursty sender,
    // a stalling receiver, and light idling on both sides.
    fill_up = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 54; end
        default: begin send_gap_pct = 9;  recv_stall_pct = 9;  end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (scoreboard.fill == LIST_DEPTH && $urandom_range(3) == 0) fill_up = 1'b0;
        if (scoreboard.fill == 0 && $urandom_range(3) == 0) fill_up = 1'b1;
        if ($urandom_range(39) == 0) fill_up = ~fill_up;
        send_random(fill_up);
      end
    end

    // Let the last results come out; the watchdog bounds the wait.
    in_valid_i <= 1'b0;
    while (scoreboard.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts, %0d deletes, %0d reads and %0d unused codes; peak fill %0d.",
             scoreboard.op_tally[pidl_pkg::CMD_INSERT], scoreboard.op_tally[pidl_pkg::CMD_DELETE],
             scoreboard.op_tally[pidl_pkg::CMD_READ], scoreboard.op_tally[CMD_UNUSED],
             scoreboard.peak_fill);
    $display("Answers seen: %0d ok, %0d full, %0d empty, %0d out of range; %0d mismatches.",
             scoreboard.status_tally[pidl_pkg::ST_OK],
             scoreboard.status_tally[pidl_pkg::ST_FULL],
             scoreboard.status_tally[pidl_pkg::ST_EMPTY],
             scoreboard.status_tally[pidl_pkg::ST_RANGE],
             scoreboard.mismatches);
    if (scoreboard.mismatches == 0 && scoreboard.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
